// ===== design/assert_macros.svh =====
// Assertion macros shared by the parking path core.
// Depends on nothing; included by files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, cond)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/ppap_pkg.sv =====
// Types and constants for the two-arc parking path core.
// Depends on nothing.
`timescale 1ns / 1ps
package ppap_pkg;
  localparam int unsigned XW = 17;
  localparam int unsigned YW = 18;
  localparam int unsigned CW = 16;
  localparam int unsigned RADW = 36;   // radicands are below 2^35, plus sign
  localparam int unsigned ROOTW = 18;  // floor(sqrt) of a 36-bit value
  localparam int unsigned NCELL = 18;
  localparam logic [0:0] REG_RADIUS = 1'b0;
  localparam logic [0:0] REG_SADDLE = 1'b1;

  typedef struct packed {
    logic [RADW-1:0] rem1;
    logic [ROOTW-1:0] root1;
    logic [RADW-1:0] rem2;
    logic [ROOTW-1:0] root2;
    logic second;
    logic bad;
  } sq_word_t;
endpackage

// ===== design/ppap_if.sv =====
// Valid/ready channel interfaces used on the ports of the core.
// Depends on ppap_pkg.
`timescale 1ns / 1ps
interface ppap_in_if;
  import ppap_pkg::*;
  logic valid;
  logic ready;
  logic signed [XW-1:0] query_x;
  modport source (output valid, output query_x, input ready);
  modport sink (input valid, input query_x, output ready);
endinterface

interface ppap_out_if;
  import ppap_pkg::*;
  logic valid;
  logic ready;
  logic signed [YW-1:0] path_y;
  logic invalid;
  modport source (output valid, output path_y, output invalid, input ready);
  modport sink (input valid, input path_y, input invalid, output ready);
endinterface

interface ppap_cfg_if;
  import ppap_pkg::*;
  logic valid;
  logic ready;
  logic [0:0] index;
  logic [CW-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== design/ppap_sqrt_cell.sv =====
// One cell of the square-root chain: resolves one root bit of both radicands.
// Depends on ppap_pkg.
`timescale 1ns / 1ps
module ppap_sqrt_cell #(
  parameter int unsigned STEP = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                vld_in,
  input  ppap_pkg::sq_word_t  word_in,
  output logic                vld_out,
  output ppap_pkg::sq_word_t  word_out
);
  import ppap_pkg::*;
  localparam int unsigned SH = 2 * (NCELL - 1 - STEP);

  logic vld_r;
  sq_word_t word_r, word_nxt;
  logic [RADW:0] trial1, trial2;

  always_comb begin
    word_nxt = word_in;
    trial1 = {1'b0, word_in.rem1} -
             (({{(RADW+1-ROOTW){1'b0}}, word_in.root1} << (SH + 2)) |
              ({{RADW{1'b0}}, 1'b1} << SH));
    trial2 = {1'b0, word_in.rem2} -
             (({{(RADW+1-ROOTW){1'b0}}, word_in.root2} << (SH + 2)) |
              ({{RADW{1'b0}}, 1'b1} << SH));
    if (!trial1[RADW]) begin
      word_nxt.rem1 = trial1[RADW-1:0];
      word_nxt.root1 = {word_in.root1[ROOTW-2:0], 1'b1};
    end else begin
      word_nxt.root1 = {word_in.root1[ROOTW-2:0], 1'b0};
    end
    if (!trial2[RADW]) begin
      word_nxt.rem2 = trial2[RADW-1:0];
      word_nxt.root2 = {word_in.root2[ROOTW-2:0], 1'b1};
    end else begin
      word_nxt.root2 = {word_in.root2[ROOTW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      word_r <= word_nxt;
    end
  end

  assign vld_out = vld_r;
  assign word_out = word_r;
endmodule

// ===== design/parallel_parking_arc_path_core.sv =====
// Top level of the two-arc parallel-parking path core.
// Depends on ppap_pkg, the channel interfaces, ppap_sqrt_cell and assert_macros.svh.
//
//  channel | dir | fields
//  in_     | in  | query_x
//  out_    | out | path_y, invalid
//  cfg_    | in  | index, data
//
// One word is accepted per cycle while the output does not stall; there are
// three front-end stages, an eighteen-cell square-root chain, one output stage.
// The whole pipeline advances together and stalls only while a finished
// word waits at the output. Reset empties the pipeline and restores the
// radius to 1.0 and the saddle point to 0.5.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module parallel_parking_arc_path_core (
  input  logic      clk,
  input  logic      rst_n,
  ppap_in_if.sink   in_ch,
  ppap_out_if.source out_ch,
  ppap_cfg_if.sink  cfg_ch
);
  import ppap_pkg::*;

  logic [CW-1:0] radius_r, saddle_r;
  logic en;
  assign en = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= 16'd64;
      saddle_r <= 16'd32;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_RADIUS: radius_r <= cfg_ch.data;
        REG_SADDLE: saddle_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // Stage 1: differences and operands.
  logic v1_r, sec1_r;
  logic signed [19:0] d1_r;
  logic signed [17:0] tb1_r;
  logic [CW-1:0] a1_r, b1_r;
  logic signed [19:0] c_w, d_w;
  always_comb begin
    c_w = $signed({3'b0, saddle_r, 1'b0}) - $signed({4'b0, radius_r});
    if ($signed({in_ch.query_x[XW-1], in_ch.query_x}) <= $signed({2'b0, saddle_r}))
      d_w = $signed({{3{in_ch.query_x[XW-1]}}, in_ch.query_x}) -
            $signed({4'b0, radius_r});
    else
      d_w = $signed({{3{in_ch.query_x[XW-1]}}, in_ch.query_x}) - c_w;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (en) v1_r <= in_ch.valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sec1_r <= $signed({in_ch.query_x[XW-1], in_ch.query_x}) >
                $signed({2'b0, saddle_r});
      d1_r <= d_w;
      tb1_r <= $signed({1'b0, radius_r, 1'b0}) - $signed({2'b0, saddle_r});
      a1_r <= radius_r;
      b1_r <= saddle_r;
    end
  end

  // Stage 2: products.
  logic v2_r, sec2_r;
  logic [31:0] aa2_r;
  logic [37:0] dd2_r;
  logic signed [35:0] br2_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (en) v2_r <= v1_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sec2_r <= sec1_r;
      aa2_r <= a1_r * a1_r;
      dd2_r <= 38'(d1_r * d1_r);
      br2_r <= 36'($signed({1'b0, b1_r}) * tb1_r);
    end
  end

  // Stage 3: radicands and sign checks.
  logic v3_r;
  sq_word_t w3_r;
  logic signed [38:0] r1_w, r2_w;
  always_comb begin
    r1_w = $signed({7'b0, aa2_r}) - $signed({1'b0, dd2_r});
    r2_w = 39'(br2_r) <<< 2;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (en) v3_r <= v2_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      w3_r.second <= sec2_r;
      w3_r.bad <= r1_w[38] || (sec2_r && r2_w[38]);
      w3_r.rem1 <= r1_w[38] ? '0 : r1_w[RADW-1:0];
      w3_r.rem2 <= (r2_w[38] || !sec2_r) ? '0 : r2_w[RADW-1:0];
      w3_r.root1 <= '0;
      w3_r.root2 <= '0;
    end
  end

  logic vc [NCELL+1];
  sq_word_t wc [NCELL+1];
  assign vc[0] = v3_r;
  assign wc[0] = w3_r;
  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    ppap_sqrt_cell #(.STEP(i)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .vld_in(vc[i]), .word_in(wc[i]),
      .vld_out(vc[i+1]), .word_out(wc[i+1])
    );
  end

  logic vo_r, bad_r;
  logic signed [YW-1:0] y_r;
  always_ff @(posedge clk) begin
    if (!rst_n) vo_r <= 1'b0;
    else if (en) vo_r <= vc[NCELL];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      bad_r <= wc[NCELL].bad;
      if (wc[NCELL].bad) y_r <= '0;
      else if (wc[NCELL].second)
        y_r <= $signed({1'b0, wc[NCELL].root1[ROOTW-2:0]}) -
               $signed({1'b0, wc[NCELL].root2[ROOTW-2:0]});
      else
        y_r <= -$signed({1'b0, wc[NCELL].root1[ROOTW-2:0]});
    end
  end

  assign out_ch.valid = vo_r;
  assign out_ch.path_y = y_r;
  assign out_ch.invalid = bad_r;

  `ASSERT_IMPL(a_bad_zero, clk, rst_n, !(out_ch.valid && out_ch.invalid) || out_ch.path_y == '0)
  `ASSERT_NEXT(a_hold, clk, rst_n, out_ch.valid && !out_ch.ready, out_ch.valid && $stable(out_ch.path_y))
  `ASSERT_IMPL(a_ready, clk, rst_n, in_ch.ready == (!out_ch.valid || out_ch.ready))
endmodule

// ===== verif/ppap_checker.sv =====
// Checker for the two-arc parking path core: predicts each result word from
// the accepted query words and the current radius and saddle point.
// Depends on ppap_pkg and the channel interfaces in design/ppap_if.sv.
`timescale 1ns / 1ps
module ppap_checker
  import ppap_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  ppap_in_if         in_ch,
  ppap_out_if        out_ch,
  ppap_cfg_if        cfg_ch,
  output int         fail_count,
  output int         pending
);
  typedef struct {
    logic signed [YW-1:0] y;
    logic                 bad;
  } path_pt_t;

  path_pt_t       path_q[$];
  logic [CW-1:0]  rad_reg;
  logic [CW-1:0]  sad_reg;

  function automatic longint floor_root(longint v);
    longint res;
    longint bitv;
    res = 0;
    bitv = 64'sd1 <<< 62;
    while (bitv > v) bitv = bitv >>> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >>> 1) + bitv;
      end else begin
        res = res >>> 1;
      end
      bitv = bitv >>> 2;
    end
    return res;
  endfunction

  function automatic path_pt_t arc_point(logic signed [XW-1:0] qx);
    path_pt_t p;
    longint x, a, b, d, r1, r2, y;
    x = qx;
    a = rad_reg;
    b = sad_reg;
    p.bad = 1'b0;
    y = 0;
    if (x <= b) begin
      d = x - a;
      r1 = a * a - d * d;
      if (r1 < 0) p.bad = 1'b1;
      else y = -floor_root(r1);
    end else begin
      d = x - (2 * b - a);
      r1 = a * a - d * d;
      r2 = 4 * b * (2 * a - b);
      if (r1 < 0 || r2 < 0) p.bad = 1'b1;
      else y = floor_root(r1) - floor_root(r2);
    end
    if (p.bad) y = 0;
    if (y > 131071) y = 131071;
    if (y < -131072) y = -131072;
    p.y = y[YW-1:0];
    return p;
  endfunction

  assign pending = path_q.size();

  always @(posedge clk) begin
    path_pt_t e;
    if (!rst_n) begin
      rad_reg <= 16'd64;
      sad_reg <= 16'd32;
      path_q.delete();
      fail_count <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) path_q.push_back(arc_point(in_ch.query_x));
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.index == REG_RADIUS) rad_reg <= cfg_ch.data;
        else if (cfg_ch.index == REG_SADDLE) sad_reg <= cfg_ch.data;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (path_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result word y=%0d", out_ch.path_y);
          fail_count <= fail_count + 1;
        end else begin
          e = path_q.pop_front();
          if (e.y !== out_ch.path_y || e.bad !== out_ch.invalid) begin
            if (fail_count < 10)
              $display("mismatch: expected y=%0d inv=%0b, got y=%0d inv=%0b",
                       e.y, e.bad, out_ch.path_y, out_ch.invalid);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// ===== verif/tb.sv =====
// Testbench top for the parking path core: drives query and register words
// with random gaps and stalls, and gives the verdict from the checker.
// Depends on ppap_pkg, the channel interfaces, the core and ppap_checker.
`timescale 1ns / 1ps
module tb;
  import ppap_pkg::*;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   cycles;
  logic [CW-1:0] cur_rad;
  logic [CW-1:0] cur_sad;

  ppap_in_if  in_ch ();
  ppap_out_if out_ch ();
  ppap_cfg_if cfg_ch ();

  parallel_parking_arc_path_core DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  ppap_checker chk (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 400000) begin
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  initial begin
    int g;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 9) < 3) begin
        g = gap_len();
        if (g > 0) begin
          out_ch.ready <= 1'b0;
          repeat (g) @(posedge clk);
        end
      end
      out_ch.ready <= 1'b1;
    end
  end

  task automatic send_query(logic signed [XW-1:0] qx, bit no_gap);
    int g;
    g = no_gap ? 0 : gap_len();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.query_x <= qx;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [CW-1:0] val);
    drain();
    repeat (30) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == REG_RADIUS) cur_rad = val;
    else cur_sad = val;
  endtask

  function automatic logic signed [XW-1:0] near_path();
    int lo, hi;
    lo = 2 * int'(cur_sad) - 2 * int'(cur_rad) - 8;
    hi = (int'(cur_sad) > int'(cur_rad) ? 2 * int'(cur_sad) : 2 * int'(cur_rad)) + 8;
    if (lo < -65536) lo = -65536;
    if (hi > 65535) hi = 65535;
    if (lo > hi) lo = hi;
    return XW'($urandom_range(hi - lo, 0) + lo);
  endfunction

  initial begin
    logic signed [XW-1:0] qx;
    logic signed [XW-1:0] corner_x [12];
    bit burst;
    in_ch.valid <= 1'b0;
    in_ch.query_x <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= REG_RADIUS;
    cfg_ch.data <= '0;
    cur_rad = 16'd64;
    cur_sad = 16'd32;
    corner_x = '{17'sd0, 17'sd32, 17'sd33, 17'sd64, 17'sd128, 17'sd129, -17'sd1, -17'sd64,
                 17'sd65535, -17'sd65536, 17'sd100, 17'sd10};
    rst_n <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Reset setting: both arcs, the saddle itself, the circle edges and extremes.
    foreach (corner_x[i]) begin
      send_query(corner_x[i], 1'b0);
    end
    // Zero radius: only x = 0 is valid on the first arc.
    write_reg(REG_RADIUS, 16'd0);
    write_reg(REG_SADDLE, 16'd0);
    send_query(17'sd0, 1'b0);
    send_query(17'sd1, 1'b0);
    send_query(-17'sd1, 1'b0);
    // Saddle beyond twice the radius makes the second centre imaginary.
    write_reg(REG_RADIUS, 16'd10);
    write_reg(REG_SADDLE, 16'd30);
    send_query(17'sd31, 1'b0);
    send_query(17'sd5, 1'b0);
    // Largest registers.
    write_reg(REG_RADIUS, 16'hFFFF);
    write_reg(REG_SADDLE, 16'hFFFF);
    send_query(17'sd65535, 1'b0);
    send_query(-17'sd65536, 1'b0);
    send_query(17'sd0, 1'b0);
    write_reg(REG_SADDLE, 16'd0);
    send_query(17'sd65535, 1'b0);
    send_query(17'sd1, 1'b0);

    for (int ph = 0; ph < 12; ph++) begin
      unique case (ph % 4)
        0: write_reg(REG_RADIUS, 16'($urandom_range(1, 400)));
        1: write_reg(REG_RADIUS, 16'($urandom_range(1, 65535)));
        2: write_reg(REG_RADIUS, 16'd1);
        default: write_reg(REG_RADIUS, 16'hFFFF);
      endcase
      if ($urandom_range(0, 3) == 0) write_reg(REG_SADDLE, 16'($urandom));
      else write_reg(REG_SADDLE, 16'($urandom_range(0, 2 * int'(cur_rad) > 65535 ?
                                                      65535 : 2 * int'(cur_rad))));
      burst = ($urandom_range(0, 2) == 0);
      for (int n = 0; n < 150; n++) begin
        if ($urandom_range(0, 9) < 8) qx = near_path();
        else qx = XW'($urandom);
        send_query(qx, burst);
        if (ph == 5 && n == 70) drain();
      end
    end

    drain();
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+design
design/ppap_pkg.sv
design/ppap_if.sv
design/ppap_sqrt_cell.sv
design/parallel_parking_arc_path_core.sv
verif/ppap_checker.sv
verif/tb.sv
